FILE: hdl/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg
// Shared widths, request codes and control types for the FIFO queue with
// running statistics.
// ----------------------------------------------------------------------------
package fqs_pkg;

  // Width of one stored entry.
  localparam int DATA_W = 32;

  // Request operation codes.
  localparam logic [1:0] OP_ENQ    = 2'd0;
  localparam logic [1:0] OP_DEQ    = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [1:0] STS_OK        = 2'd0;
  localparam logic [1:0] STS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STS_OVERFLOW  = 2'd2;

  // Control from the scan sequencer to the statistics unit.
  typedef struct packed {
    logic clear;   // a new request starts, reset the accumulators
    logic sample;  // memory read data holds the next entry in queue order
  } fqs_ctl_t;

endpackage

FILE: hdl/fqs_stats.sv
// ----------------------------------------------------------------------------
// fqs_stats
// Accumulates front, maximum, minimum, exact sum, search hit and the three
// largest distinct values over entries streamed in queue order.
// ----------------------------------------------------------------------------
module fqs_stats import fqs_pkg::*; #(
  parameter int SUM_W = 38
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fqs_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic signed [DATA_W-1:0] key_i,
  output logic signed [DATA_W-1:0] front_o,
  output logic signed [DATA_W-1:0] max_o,
  output logic signed [DATA_W-1:0] min_o,
  output logic signed [SUM_W-1:0]  sum_o,
  output logic signed [DATA_W-1:0] third_o,
  output logic                     third_vld_o,
  output logic                     found_o
);

  logic                     first_r;
  logic                     found_r;
  logic [1:0]               ntop_r;
  logic signed [DATA_W-1:0] front_r;
  logic signed [DATA_W-1:0] max_r;
  logic signed [DATA_W-1:0] min_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [DATA_W-1:0] top0_r;
  logic signed [DATA_W-1:0] top1_r;
  logic signed [DATA_W-1:0] top2_r;

  logic dup;

  // A sample already in the top list does not count again.
  assign dup = ((ntop_r != 2'd0) && (top0_r == sample_i)) ||
               ((ntop_r >= 2'd2) && (top1_r == sample_i)) ||
               ((ntop_r == 2'd3) && (top2_r == sample_i));

  // Accumulators, cleared at the start of every request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
      found_r <= 1'b0;
      ntop_r  <= 2'd0;
    end else if (ctl_i.clear) begin
      first_r <= 1'b1;
      found_r <= 1'b0;
      ntop_r  <= 2'd0;
      front_r <= '0;
      max_r   <= '0;
      min_r   <= '0;
      sum_r   <= '0;
      top0_r  <= '0;
      top1_r  <= '0;
      top2_r  <= '0;
    end else if (ctl_i.sample) begin
      first_r <= 1'b0;
      if (first_r) begin
        front_r <= sample_i;
        max_r   <= sample_i;
        min_r   <= sample_i;
      end else begin
        if (sample_i > max_r) begin
          max_r <= sample_i;
        end
        if (sample_i < min_r) begin
          min_r <= sample_i;
        end
      end
      sum_r <= sum_r + SUM_W'(sample_i);
      if (sample_i == key_i) begin
        found_r <= 1'b1;
      end
      // Insert into the descending list of up to three distinct values.
      if (!dup) begin
        if (ntop_r == 2'd0) begin
          top0_r <= sample_i;
          ntop_r <= 2'd1;
        end else if (sample_i > top0_r) begin
          top2_r <= top1_r;
          top1_r <= top0_r;
          top0_r <= sample_i;
          if (ntop_r != 2'd3) begin
            ntop_r <= ntop_r + 2'd1;
          end
        end else if ((ntop_r == 2'd1) || (sample_i > top1_r)) begin
          top2_r <= top1_r;
          top1_r <= sample_i;
          if (ntop_r != 2'd3) begin
            ntop_r <= ntop_r + 2'd1;
          end
        end else if ((ntop_r == 2'd2) || (sample_i > top2_r)) begin
          top2_r <= sample_i;
          ntop_r <= 2'd3;
        end
      end
    end
  end

  assign front_o     = front_r;
  assign max_o       = max_r;
  assign min_o       = min_r;
  assign sum_o       = sum_r;
  assign found_o     = found_r;
  assign third_vld_o = (ntop_r == 2'd3);
  assign third_o     = (ntop_r == 2'd3) ? top2_r : '0;

endmodule

FILE: hdl/fifo_queue_with_statistics.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_statistics
// Bounded ring FIFO of signed entries in one synchronous memory; every request
// rescans the held entries to report count, front, max, min, sum and the
// third-largest distinct value.
// ----------------------------------------------------------------------------
// Sequence: a successful dequeue first reads and retires the front entry
// (ST_POP_RD, ST_POP_WB); every request then rescans the held entries in
// ST_SCAN and registers its result in ST_DONE. The next request is accepted
// only after the result is registered; the single memory read port, one entry
// per cycle during the rescan, paces the scan. A stalled result holds the
// sequencer. Reset clears the pointers, the count and all handshake state; the
// entry memory is not cleared and only held entries are ever sampled for the
// statistics.
module fifo_queue_with_statistics import fqs_pkg::*; #(
  parameter  int QUEUE_DEPTH = 64,
  localparam int PW          = $clog2(QUEUE_DEPTH),
  localparam int CW          = $clog2(QUEUE_DEPTH + 1),
  localparam int SUM_W       = DATA_W + PW
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               out_status,
  output logic signed [DATA_W-1:0] out_popped_value,
  output logic                     out_found,
  output logic [CW-1:0]            out_item_count,
  output logic signed [DATA_W-1:0] out_front_value,
  output logic signed [DATA_W-1:0] out_largest,
  output logic signed [DATA_W-1:0] out_smallest,
  output logic signed [SUM_W-1:0]  out_total,
  output logic signed [DATA_W-1:0] out_third_largest,
  output logic                     out_third_valid
);

  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [PW-1:0] LAST_A  = PW'(QUEUE_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_POP_WB,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state_r;

  logic [PW-1:0]            front_r;
  logic [CW-1:0]            count_r;
  logic [PW-1:0]            scan_addr_r;
  logic [CW-1:0]            issue_cnt_r;
  logic                     rd_pend_r;
  logic [1:0]               op_r;
  logic signed [DATA_W-1:0] value_r;
  logic [1:0]               status_r;
  logic signed [DATA_W-1:0] popped_r;
  logic                     out_valid_r;

  // Output registers.
  logic [1:0]               out_status_r;
  logic signed [DATA_W-1:0] out_popped_r;
  logic                     out_found_r;
  logic [CW-1:0]            out_count_r;
  logic signed [DATA_W-1:0] out_front_r;
  logic signed [DATA_W-1:0] out_max_r;
  logic signed [DATA_W-1:0] out_min_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic signed [DATA_W-1:0] out_third_r;
  logic                     out_third_vld_r;

  // Entry memory.
  logic signed [DATA_W-1:0] mem [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  logic          accept;
  logic          full;
  logic          mem_we;
  logic [PW:0]   tail_sum;
  logic [PW-1:0] tail;
  logic [PW-1:0] front_inc;
  logic [PW-1:0] scan_inc;
  logic          out_free;

  fqs_ctl_t                 stat_ctl;
  logic signed [DATA_W-1:0] st_front;
  logic signed [DATA_W-1:0] st_max;
  logic signed [DATA_W-1:0] st_min;
  logic signed [SUM_W-1:0]  st_sum;
  logic signed [DATA_W-1:0] st_third;
  logic                     st_third_vld;
  logic                     st_found;

  // Handshake and address arithmetic.
  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (count_r == DEPTH_C);
  assign mem_we    = accept && (in_op == OP_ENQ) && !full;
  assign out_free  = !out_valid_r || out_ready;

  // Tail slot: front plus count, wrapped once around the ring.
  assign tail_sum  = (PW + 1)'(front_r) + (PW + 1)'(count_r);
  assign tail      = (tail_sum >= DEPTH_P) ? PW'(tail_sum - DEPTH_P) : PW'(tail_sum);
  assign front_inc = (front_r == LAST_A) ? '0 : front_r + PW'(1);
  assign scan_inc  = (scan_addr_r == LAST_A) ? '0 : scan_addr_r + PW'(1);

  // Memory: one write port for enqueue, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail] <= in_value;
    end
    rd_data_r <= mem[scan_addr_r];
  end

  // Statistics unit control.
  assign stat_ctl.clear  = accept;
  assign stat_ctl.sample = rd_pend_r;

  fqs_stats #(
    .SUM_W (SUM_W)
  ) u_stats (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (stat_ctl),
    .sample_i    (rd_data_r),
    .key_i       (value_r),
    .front_o     (st_front),
    .max_o       (st_max),
    .min_o       (st_min),
    .sum_o       (st_sum),
    .third_o     (st_third),
    .third_vld_o (st_third_vld),
    .found_o     (st_found)
  );

  // Request sequencer, queue pointers and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      scan_addr_r <= '0;
      issue_cnt_r <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // A result leaves on its handshake unless the next one takes its place.
      if (out_valid_r && out_ready && (state_r != ST_DONE)) begin
        out_valid_r <= 1'b0;
      end
      // Read data is valid in the cycle after each scan read is issued.
      rd_pend_r <= (state_r == ST_SCAN) && (issue_cnt_r < count_r);
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r        <= in_op;
            value_r     <= in_value;
            popped_r    <= '0;
            scan_addr_r <= front_r;
            issue_cnt_r <= '0;
            case (in_op)
              OP_ENQ: begin
                state_r <= ST_SCAN;
                if (full) begin
                  status_r <= STS_OVERFLOW;
                end else begin
                  status_r <= STS_OK;
                  count_r  <= count_r + CW'(1);
                end
              end
              OP_DEQ: begin
                if (count_r == '0) begin
                  status_r <= STS_UNDERFLOW;
                  state_r  <= ST_SCAN;
                end else begin
                  status_r <= STS_OK;
                  state_r  <= ST_POP_RD;
                end
              end
              default: begin
                status_r <= STS_OK;
                state_r  <= ST_SCAN;
              end
            endcase
          end
        end
        ST_POP_RD: begin
          // Memory captures the front entry at this edge.
          state_r <= ST_POP_WB;
        end
        ST_POP_WB: begin
          popped_r    <= rd_data_r;
          front_r     <= front_inc;
          scan_addr_r <= front_inc;
          count_r     <= count_r - CW'(1);
          state_r     <= ST_SCAN;
        end
        ST_SCAN: begin
          // Read every held entry in queue order, one per cycle.
          if (issue_cnt_r < count_r) begin
            issue_cnt_r <= issue_cnt_r + CW'(1);
            scan_addr_r <= scan_inc;
          end else if (!rd_pend_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_status_r    <= status_r;
            out_popped_r    <= popped_r;
            out_found_r     <= (op_r == OP_SEARCH) && st_found;
            out_count_r     <= count_r;
            out_front_r     <= st_front;
            out_max_r       <= st_max;
            out_min_r       <= st_min;
            out_sum_r       <= st_sum;
            out_third_r     <= st_third;
            out_third_vld_r <= st_third_vld;
            state_r         <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_popped_value  = out_popped_r;
  assign out_found         = out_found_r;
  assign out_item_count    = out_count_r;
  assign out_front_value   = out_front_r;
  assign out_largest       = out_max_r;
  assign out_smallest      = out_min_r;
  assign out_total         = out_sum_r;
  assign out_third_largest = out_third_r;
  assign out_third_valid   = out_third_vld_r;

endmodule

FILE: tb/fqs_stats_checker.sv
// ----------------------------------------------------------------------------
// fqs_stats_checker
// Watches the request and result channels of the statistics FIFO. It keeps its own copy
// of the held entries, works out the expected result of each accepted
// request, and compares every returned result field by field.
// ----------------------------------------------------------------------------
module fqs_stats_checker import fqs_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [1:0]               in_op,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [1:0]               out_status,
  input  logic signed [DATA_W-1:0] out_popped_value,
  input  logic                     out_found,
  input  logic [6:0]               out_item_count,
  input  logic signed [DATA_W-1:0] out_front_value,
  input  logic signed [DATA_W-1:0] out_largest,
  input  logic signed [DATA_W-1:0] out_smallest,
  input  logic signed [37:0]       out_total,
  input  logic signed [DATA_W-1:0] out_third_largest,
  input  logic                     out_third_valid,
  output int                       fail_count,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped;
    logic                     found;
    logic [6:0]               count;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] largest;
    logic signed [DATA_W-1:0] smallest;
    logic signed [37:0]       total;
    logic signed [DATA_W-1:0] third;
    logic                     third_valid;
  } queue_stats_t;

  // Entries held by the queue, oldest first.
  int held[$];
  // Results still owed by the block, oldest first.
  queue_stats_t stats_due[$];
  int mismatches = 0;
  int outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the held entries and return the statistics after it.
  function automatic queue_stats_t apply_request(input logic [1:0] op,
                                                 input logic signed [DATA_W-1:0] v);
    queue_stats_t s;
    int first, second, third, distinct, x;
    longint acc;
    s = '{default: '0};
    s.status = STS_OK;
    case (op)
      OP_ENQ: begin
        if (held.size() >= DEPTH) s.status = STS_OVERFLOW;
        else held.push_back(v);
      end
      OP_DEQ: begin
        if (held.size() == 0) s.status = STS_UNDERFLOW;
        else s.popped = held.pop_front();
      end
      OP_SEARCH: begin
        foreach (held[i]) if (held[i] == v) s.found = 1'b1;
      end
      default: ;
    endcase

    // Rescan the held entries; duplicates count once in the top three.
    acc = 0;
    distinct = 0;
    first = 0;
    second = 0;
    third = 0;
    foreach (held[i]) begin
      x = held[i];
      if (i == 0) begin
        s.front = x;
        s.largest = x;
        s.smallest = x;
      end else begin
        if (x > s.largest) s.largest = x;
        if (x < s.smallest) s.smallest = x;
      end
      acc += x;
      if ((distinct >= 1 && x == first) || (distinct >= 2 && x == second) ||
          (distinct >= 3 && x == third)) begin
        // Already ranked.
      end else if (distinct == 0 || x > first) begin
        third = second;
        second = first;
        first = x;
        if (distinct < 3) distinct++;
      end else if (distinct == 1 || x > second) begin
        third = second;
        second = x;
        if (distinct < 3) distinct++;
      end else if (distinct == 2 || x > third) begin
        third = x;
        if (distinct < 3) distinct++;
      end
    end
    s.count = 7'(held.size());
    s.total = acc[37:0];
    s.third_valid = (distinct >= 3);
    s.third = (distinct >= 3) ? third : 0;
    return s;
  endfunction

  // Compare returned results first, then record the newly accepted request.
  always @(posedge clk) begin
    queue_stats_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (stats_due.size() == 0) begin
          report_mismatch("unrequested result, status", out_status, 0);
        end else begin
          want = stats_due.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_popped_value !== want.popped)
            report_mismatch("popped_value", out_popped_value, want.popped);
          if (out_found !== want.found)
            report_mismatch("found", out_found, want.found);
          if (out_item_count !== want.count)
            report_mismatch("item_count", out_item_count, want.count);
          if (out_front_value !== want.front)
            report_mismatch("front_value", out_front_value, want.front);
          if (out_largest !== want.largest)
            report_mismatch("largest", out_largest, want.largest);
          if (out_smallest !== want.smallest)
            report_mismatch("smallest", out_smallest, want.smallest);
          if (out_total !== want.total)
            report_mismatch("total", out_total, want.total);
          if (out_third_largest !== want.third)
            report_mismatch("third_largest", out_third_largest, want.third);
          if (out_third_valid !== want.third_valid)
            report_mismatch("third_valid", out_third_valid, want.third_valid);
        end
      end
      if (in_valid && in_ready) stats_due.push_back(apply_request(in_op, in_value));
      outstanding = stats_due.size();
    end
  end

endmodule

FILE: tb/fifo_queue_with_statistics_tb.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_statistics_tb
// Drives enqueue, dequeue, search and unused-code requests into the FIFO with
// random gaps and result stalls: a directed opening, then fill, drain and
// mixed phases. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module fifo_queue_with_statistics_tb import fqs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 64;
  localparam int ITEMS = 1500;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 80;
  // The fourth operation code has no meaning and must leave the queue alone.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] MIN_VAL = 32'sh8000_0000;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_op = OP_ENQ;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               out_status;
  logic signed [DATA_W-1:0] out_popped_value;
  logic                     out_found;
  logic [6:0]               out_item_count;
  logic signed [DATA_W-1:0] out_front_value;
  logic signed [DATA_W-1:0] out_largest;
  logic signed [DATA_W-1:0] out_smallest;
  logic signed [37:0]       out_total;
  logic signed [DATA_W-1:0] out_third_largest;
  logic                     out_third_valid;
  int                       fail_count;
  int                       pending;

  // Stimulus bookkeeping: queue level as the requests imply, recent values.
  int   level = 0;
  int   sent = 0;
  bit   quiet = 1'b0;
  int   recent[16];
  int   recent_idx = 0;
  int   idle_cycles = 0;

  always #5 clk = ~clk;

  fifo_queue_with_statistics #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_value  (out_popped_value),
    .out_found         (out_found),
    .out_item_count    (out_item_count),
    .out_front_value   (out_front_value),
    .out_largest       (out_largest),
    .out_smallest      (out_smallest),
    .out_total         (out_total),
    .out_third_largest (out_third_largest),
    .out_third_valid   (out_third_valid)
  );

  fqs_stats_checker #(.DEPTH(DEPTH)) u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_popped_value  (out_popped_value),
    .out_found         (out_found),
    .out_item_count    (out_item_count),
    .out_front_value   (out_front_value),
    .out_largest       (out_largest),
    .out_smallest      (out_smallest),
    .out_total         (out_total),
    .out_third_largest (out_third_largest),
    .out_third_valid   (out_third_valid),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // The run ends if neither channel moves a request for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result, none in quiet phases.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return MAX_VAL;
      1: return MIN_VAL;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  // Wide random values most often, then small ones and recent values for duplicates, and extremes.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6: return int'($urandom_range(0, 8)) - 4;
      7: return pick_extreme();
      default: return recent[$urandom_range(0, 15)];
    endcase
  endfunction

  // Searches usually look for something recently enqueued.
  function automatic logic signed [DATA_W-1:0] search_value();
    if ($urandom_range(0, 9) < 7) return recent[$urandom_range(0, 15)];
    return pick_value();
  endfunction

  function automatic logic [1:0] mixed_op();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return OP_ENQ;
    if (r < 15) return OP_DEQ;
    if (r < 19) return OP_SEARCH;
    return OP_UNUSED;
  endfunction

  // Present one request after a random gap and hold it until accepted.
  task automatic send_request(input logic [1:0] op, input logic signed [DATA_W-1:0] v);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op = op;
    in_value = v;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
    if (op == OP_ENQ && level < DEPTH) begin
      level++;
      recent[recent_idx] = v;
      recent_idx = (recent_idx + 1) % 16;
    end else if (op == OP_DEQ && level > 0) begin
      level--;
    end
  endtask

  task automatic send_mixed();
    logic [1:0] op;
    op = mixed_op();
    send_request(op, (op == OP_SEARCH) ? search_value() : pick_value());
  endtask

  initial begin
    logic signed [DATA_W-1:0] fill_val;
    bit fixed;
    foreach (recent[i]) recent[i] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed opening: empty-queue cases, extremes, duplicates, misses.
    send_request(OP_DEQ, 0);
    send_request(OP_SEARCH, 0);
    send_request(OP_UNUSED, -1);
    send_request(OP_ENQ, MAX_VAL);
    send_request(OP_ENQ, MIN_VAL);
    send_request(OP_ENQ, MAX_VAL);
    send_request(OP_ENQ, 0);
    send_request(OP_ENQ, -1);
    send_request(OP_SEARCH, MIN_VAL);
    send_request(OP_SEARCH, 12345);
    send_request(OP_UNUSED, 32'sh5555_5555);
    send_request(OP_ENQ, 32'shAAAA_AAAA);
    while (level > 0) send_request(OP_DEQ, 0);
    send_request(OP_DEQ, -1);
    send_request(OP_SEARCH, -1);

    // Random phases: fill to overflow, drain to underflow, or a mix.
    while (sent < ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: begin
          fixed = ($urandom_range(0, 2) == 0);
          fill_val = pick_extreme();
          while (level < DEPTH) begin
            if ($urandom_range(0, 19) < 17)
              send_request(OP_ENQ, fixed ? fill_val : pick_value());
            else
              send_mixed();
          end
          repeat ($urandom_range(1, 3)) send_request(OP_ENQ, pick_value());
        end
        1: begin
          while (level > 0) begin
            if ($urandom_range(0, 19) < 17) send_request(OP_DEQ, $urandom);
            else send_mixed();
          end
          repeat ($urandom_range(1, 3)) send_request(OP_DEQ, $urandom);
        end
        default: begin
          repeat ($urandom_range(10, 60)) send_mixed();
        end
      endcase
    end
    in_valid = 1'b0;

    // Let every owed result come back, then watch for strays.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
